>>> src/asfs_pkg.sv
// Package for the case-folding substring search: sizes, codes, types and the fold function.
`timescale 1ns / 1ps
`default_nettype none
package asfs_pkg;

   localparam int MAX_NEEDLE    = 32;
   localparam int POSITION_BITS = 32;
   localparam int LEN_BITS      = 6;
   localparam int SLOT_BITS     = 5;
   localparam int BYTE_BITS     = 8;
   localparam int MODE_BITS     = 2;
   localparam int OUT_POS_BITS  = 32;
   // one bit more than the length register, so MAX_NEEDLE up to 64 compares cleanly
   localparam int CMP_BITS      = LEN_BITS + 1;
   localparam int POS_WIDE_BITS = (POSITION_BITS > OUT_POS_BITS) ? POSITION_BITS : OUT_POS_BITS;

   localparam logic [BYTE_BITS-1:0] LOWER_A  = 8'h61;
   localparam logic [BYTE_BITS-1:0] LOWER_Z  = 8'h7a;
   localparam logic [BYTE_BITS-1:0] CASE_BIT = 8'h20;

   typedef enum logic [MODE_BITS-1:0] {
      MODE_LOAD = 2'd0,
      MODE_BYTE = 2'd1,
      MODE_END  = 2'd2,
      MODE_IDLE = 2'd3
   } mode_type;

   typedef struct packed {
      logic load;    // write this cell's needle byte
      logic active;  // cell index below the active needle length
      logic top;     // cell holds the last needle byte
      logic step;    // advance the match vector
      logic clear;   // end of haystack
   } cell_ctl_type;

   typedef struct packed {
      logic                    found;
      logic [OUT_POS_BITS-1:0] position;
      logic                    overflow;
   } rsp_word_type;

   function automatic logic [BYTE_BITS-1:0] fold_byte(input logic [BYTE_BITS-1:0] c);
      logic [BYTE_BITS-1:0] r;
      r = c;
      if (c >= LOWER_A && c <= LOWER_Z) begin
         r = c - CASE_BIT;
      end
      return r;
   endfunction

endpackage
`default_nettype wire

>>> src/asfs_cell.sv
// One needle cell: stores a folded needle byte and one bit of the shift-and match vector.
`timescale 1ns / 1ps
`default_nettype none
module asfs_cell (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire asfs_pkg::cell_ctl_type         ctl,
   input  wire logic [asfs_pkg::BYTE_BITS-1:0] load_byte,
   input  wire logic [asfs_pkg::BYTE_BITS-1:0] hay_byte,
   input  wire logic                           prev_match,
   output logic                                match,
   output logic                                top_hit
);
   import asfs_pkg::*;

   logic [BYTE_BITS-1:0] needle_ff;
   logic                 match_ff;
   logic                 match_in;

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         needle_ff <= load_byte;
      end
   end

   assign match_in = prev_match & (needle_ff == hay_byte) & ctl.active;

   always_ff @(posedge clock) begin
      if (reset) begin
         match_ff <= 1'b0;
      end else if (ctl.clear) begin
         match_ff <= 1'b0;
      end else if (ctl.step) begin
         match_ff <= match_in;
      end
   end

   assign match   = match_ff;
   assign top_hit = match_in & ctl.top & ctl.step;

endmodule
`default_nettype wire

>>> src/asfs_rsp_queue.sv
// Two-word result queue between the search logic and the result channel.
`timescale 1ns / 1ps
`default_nettype none
module asfs_rsp_queue (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   push,
   input  wire asfs_pkg::rsp_word_type push_word,
   input  wire logic                   out_stall,
   output logic                        full,
   output logic                        out_valid,
   output asfs_pkg::rsp_word_type      out_word
);
   import asfs_pkg::*;

   rsp_word_type entry_ff [2];
   logic         wr_ff, wr_in;
   logic         rd_ff, rd_in;
   logic [1:0]   count_ff, count_in;
   logic         pop;

   assign out_valid = (count_ff != 2'd0);
   assign full      = (count_ff == 2'd2);
   assign pop       = out_valid & ~out_stall;
   assign out_word  = entry_ff[rd_ff];

   always_comb begin
      wr_in    = push ? ~wr_ff : wr_ff;
      rd_in    = pop ? ~rd_ff : rd_ff;
      count_in = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ff] <= push_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= 1'b0;
         rd_ff    <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

endmodule
`default_nettype wire

>>> src/ascii_fold_substring_search_core.sv
// Top level: case-folding substring search over a chain of needle cells.
//
//   channel  dir  handshake            payload
//   req_     in   req_valid/req_stall  mode, needle_slot, data_byte, last
//   rsp_     out  rsp_valid/rsp_stall  found, position, overflow
//   csr_     in   csr_valid/csr_ready  needle_length (6 bits)
//
// One input word per cycle while req_stall is low; every cell compares the broadcast
// haystack byte in the same cycle and hands its match bit to the next cell.
// A result is registered into a two-word queue and reaches rsp_ behind any unread word.
// req_stall rises only while the queue holds two words unread.
// Synchronous reset clears length, counter, flags and the match vector; needle
// bytes are undefined until loaded. csr_ready is always high.
`timescale 1ns / 1ps
`default_nettype none
module ascii_fold_substring_search_core (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_stall,
   input  wire logic [asfs_pkg::MODE_BITS-1:0]     req_mode,
   input  wire logic [asfs_pkg::SLOT_BITS-1:0]     req_needle_slot,
   input  wire logic [asfs_pkg::BYTE_BITS-1:0]     req_data_byte,
   input  wire logic                               req_last,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output logic                                    rsp_found,
   output logic [asfs_pkg::OUT_POS_BITS-1:0]       rsp_position,
   output logic                                    rsp_overflow,
   input  wire logic                               csr_valid,
   output logic                                    csr_ready,
   input  wire logic [asfs_pkg::LEN_BITS-1:0]      csr_data
);
   import asfs_pkg::*;

   logic [LEN_BITS-1:0]      len_ff, len_in;
   logic [POSITION_BITS-1:0] cnt_ff, cnt_in;
   logic                     sat_ff, sat_in;
   logic                     done_ff, done_in;

   logic                     req_acc;
   mode_type                 mode;
   logic [CMP_BITS-1:0]      n_act;
   logic                     step;
   logic                     clear;
   logic [BYTE_BITS-1:0]     hay_fold;
   logic [BYTE_BITS-1:0]     load_fold;
   logic [MAX_NEEDLE-1:0]    match_vec;
   logic [MAX_NEEDLE-1:0]    top_vec;
   logic                     any_top;
   logic [POSITION_BITS-1:0] pos_calc;
   logic [POSITION_BITS-1:0] pos_sel;
   logic [POS_WIDE_BITS-1:0] pos_wide;
   logic                     res_push;
   rsp_word_type             res_word;
   rsp_word_type             out_word;
   logic                     q_full;

   assign csr_ready = 1'b1;
   assign req_stall = q_full;
   assign req_acc   = req_valid & ~req_stall;
   assign mode      = mode_type'(req_mode);

   assign n_act = ({1'b0, len_ff} > CMP_BITS'(MAX_NEEDLE)) ? CMP_BITS'(MAX_NEEDLE)
                                                            : {1'b0, len_ff};

   assign step  = req_acc & (mode == MODE_BYTE) & ~done_ff & (n_act != '0);
   assign clear = req_acc & (((mode == MODE_BYTE) & req_last) | (mode == MODE_END));

   assign hay_fold  = fold_byte(req_data_byte);
   assign load_fold = fold_byte(req_data_byte);

   for (genvar i = 0; i < MAX_NEEDLE; i++) begin : g_cell
      cell_ctl_type ctl;
      logic         prev;

      always_comb begin
         ctl.load   = req_acc & (mode == MODE_LOAD)
                      & (CMP_BITS'(req_needle_slot) == CMP_BITS'(i));
         ctl.active = (CMP_BITS'(i) < n_act);
         ctl.top    = (CMP_BITS'(i + 1) == n_act);
         ctl.step   = step;
         ctl.clear  = clear;
      end

      if (i == 0) begin : g_head
         assign prev = 1'b1;
      end else begin : g_link
         assign prev = match_vec[i-1];
      end

      asfs_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl        (ctl),
         .load_byte  (load_fold),
         .hay_byte   (hay_fold),
         .prev_match (prev),
         .match      (match_vec[i]),
         .top_hit    (top_vec[i])
      );
   end

   assign any_top  = |top_vec;
   assign pos_calc = cnt_ff - POSITION_BITS'(n_act - CMP_BITS'(1));
   assign pos_sel  = sat_ff ? '1 : pos_calc;
   assign pos_wide = POS_WIDE_BITS'(pos_sel);

   always_comb begin
      len_in   = len_ff;
      cnt_in   = cnt_ff;
      sat_in   = sat_ff;
      done_in  = done_ff;
      res_push = 1'b0;
      res_word = '0;

      if (csr_valid & csr_ready) begin
         len_in = csr_data;
      end

      if (req_acc) begin
         unique case (mode)
            MODE_BYTE: begin
               if (!done_ff) begin
                  if (n_act == '0) begin
                     res_push       = 1'b1;
                     res_word.found = 1'b1;
                     done_in        = 1'b1;
                  end else begin
                     if (any_top) begin
                        res_push          = 1'b1;
                        res_word.found    = 1'b1;
                        res_word.position = pos_wide[OUT_POS_BITS-1:0];
                        res_word.overflow = sat_ff;
                        done_in           = 1'b1;
                     end else if (req_last) begin
                        res_push          = 1'b1;
                        res_word.overflow = sat_ff;
                     end
                     if (cnt_ff == '1) begin
                        sat_in = 1'b1;
                     end else begin
                        cnt_in = cnt_ff + POSITION_BITS'(1);
                     end
                  end
               end
               if (req_last) begin
                  cnt_in  = '0;
                  sat_in  = 1'b0;
                  done_in = 1'b0;
               end
            end
            MODE_END: begin
               if (!done_ff) begin
                  res_push          = 1'b1;
                  res_word.found    = (n_act == '0);
                  res_word.overflow = (n_act != '0) & sat_ff;
               end
               cnt_in  = '0;
               sat_in  = 1'b0;
               done_in = 1'b0;
            end
            MODE_LOAD, MODE_IDLE: begin
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff  <= '0;
         cnt_ff  <= '0;
         sat_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         len_ff  <= len_in;
         cnt_ff  <= cnt_in;
         sat_ff  <= sat_in;
         done_ff <= done_in;
      end
   end

   asfs_rsp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (res_push),
      .push_word (res_word),
      .out_stall (rsp_stall),
      .full      (q_full),
      .out_valid (rsp_valid),
      .out_word  (out_word)
   );

   assign rsp_found    = out_word.found;
   assign rsp_position = out_word.position;
   assign rsp_overflow = out_word.overflow;

endmodule
`default_nettype wire
